// ----- src/bm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bm_pkg
// Shared constants, the Booth action type and its decoder for the pipelined
// radix-2 Booth multiplier.
// ----------------------------------------------------------------------------
package bm_pkg;

    localparam int BM_WIDTH = 16;

    typedef enum logic [1:0] {
        BOOTH_NONE,
        BOOTH_ADD,
        BOOTH_SUB
    } t_booth_op;

    // pair (q0, q-1): 10 subtracts, 01 adds, 00 / 11 hold
    function automatic t_booth_op booth_decode(input logic q0, input logic qm1);
        t_booth_op op;
        case ({q0, qm1})
            2'b10:   op = BOOTH_SUB;
            2'b01:   op = BOOTH_ADD;
            default: op = BOOTH_NONE;
        endcase
        return op;
    endfunction

endpackage
`default_nettype wire

// ----- src/bm_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bm_stage
// One Booth step as a pipeline stage: add or subtract the multiplicand into
// the upper half, arithmetic right shift, register with valid and stall.
// ----------------------------------------------------------------------------
module bm_stage
    import bm_pkg::*;
#(
    parameter int WIDTH = BM_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [WIDTH:0]   i_a,
    input  wire logic [WIDTH-1:0] i_q,
    input  wire logic             i_qm1,
    input  wire logic [WIDTH-1:0] i_m,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [WIDTH:0]        o_a,
    output logic [WIDTH-1:0]      o_q,
    output logic                  o_qm1,
    output logic [WIDTH-1:0]      o_m
);

    logic             r_valid;
    logic [WIDTH:0]   r_a;
    logic [WIDTH-1:0] r_q;
    logic             r_qm1;
    logic [WIDTH-1:0] r_m;

    logic             n_valid;
    logic [WIDTH:0]   n_a;
    logic [WIDTH-1:0] n_q;
    logic             n_qm1;

    logic             load;
    logic [WIDTH:0]   m_ext;
    logic [WIDTH:0]   sum;
    t_booth_op        op;

    assign o_stall = r_valid & i_stall;
    assign load    = ~o_stall;

    assign m_ext = {i_m[WIDTH-1], i_m};
    assign op    = booth_decode(i_q[0], i_qm1);

    always_comb begin
        case (op)
            BOOTH_ADD: sum = i_a + m_ext;
            BOOTH_SUB: sum = i_a - m_ext;
            default:   sum = i_a;
        endcase
        n_a     = {sum[WIDTH], sum[WIDTH:1]};
        n_q     = {sum[0], i_q[WIDTH-1:1]};
        n_qm1   = i_q[0];
        n_valid = i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_a   <= n_a;
            r_q   <= n_q;
            r_qm1 <= n_qm1;
            r_m   <= i_m;
        end
    end

    assign o_valid = r_valid;
    assign o_a     = r_a;
    assign o_q     = r_q;
    assign o_qm1   = r_qm1;
    assign o_m     = r_m;

    a_empty_never_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> !o_stall)
        else $error("empty stage stalls upstream");

    a_held_stage_keeps_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |=> r_valid && $stable(r_a) && $stable(r_q) && $stable(r_qm1))
        else $error("stalled stage lost its contents");

    a_drain_clears_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall && !i_valid |=> !r_valid)
        else $error("stage kept a stale valid");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_valid)
        else $error("stage valid after reset");

endmodule
`default_nettype wire

// ----- src/booth_radix2_multiplier.sv -----
`timescale 1ns / 1ps
`default_nettype none
// o_valid rises once a request has passed through all WIDTH stage registers
// throughput: one request per cycle while o_stall is low; each of the WIDTH chained stages
//   does one Booth step, so the stage count sets the latency and not the rate
// a downstream stall holds occupied stages up to the first bubble; empty stages still fill
// reset: synchronous, active low; clears all stage valid bits, data is not reset
// ----------------------------------------------------------------------------
// booth_radix2_multiplier
// Signed radix-2 Booth multiplier, one Booth step per pipeline stage.
// ----------------------------------------------------------------------------
module booth_radix2_multiplier
    import bm_pkg::*;
#(
    parameter int WIDTH = BM_WIDTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [WIDTH-1:0]     i_multiplicand,
    input  wire logic [WIDTH-1:0]     i_multiplier,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [2*WIDTH-1:0]        o_product
);

    // index k is the input of stage k; index WIDTH is the last stage output
    logic             s_valid [WIDTH+1];
    logic             s_stall [WIDTH+1];
    logic [WIDTH:0]   s_a     [WIDTH+1];
    logic [WIDTH-1:0] s_q     [WIDTH+1];
    logic             s_qm1   [WIDTH+1];
    logic [WIDTH-1:0] s_m     [WIDTH+1];

    assign s_valid[0] = i_valid;
    assign s_a[0]     = '0;
    assign s_q[0]     = i_multiplier;
    assign s_qm1[0]   = 1'b0;
    assign s_m[0]     = i_multiplicand;
    assign o_stall    = s_stall[0];

    genvar k;
    generate
        for (k = 0; k < WIDTH; k++) begin : g_step
            bm_stage #(
                .WIDTH (WIDTH)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (s_valid[k]),
                .o_stall (s_stall[k]),
                .i_a     (s_a[k]),
                .i_q     (s_q[k]),
                .i_qm1   (s_qm1[k]),
                .i_m     (s_m[k]),
                .o_valid (s_valid[k+1]),
                .i_stall (s_stall[k+1]),
                .o_a     (s_a[k+1]),
                .o_q     (s_q[k+1]),
                .o_qm1   (s_qm1[k+1]),
                .o_m     (s_m[k+1])
            );
        end
    endgenerate

    assign s_stall[WIDTH] = i_stall;

    // the extra low bit is dropped; the guard bit of the upper half is redundant
    assign o_valid   = s_valid[WIDTH];
    assign o_product = {s_a[WIDTH][WIDTH-1:0], s_q[WIDTH]};

endmodule
`default_nettype wire

// ----- test/booth_radix2_multiplier_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// booth_radix2_multiplier_tb
// Self-checking bench for the radix-2 Booth multiplier: sends operand pairs
// with bursty valid and a moded downstream stall, predicts each product by
// running the Booth steps bit by bit, and compares results in order.
// ----------------------------------------------------------------------------
module booth_radix2_multiplier_tb
    import bm_pkg::*;
();

    localparam int W              = BM_WIDTH;
    localparam int WB             = $clog2(W);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 50;

    typedef struct packed {
        logic [W-1:0]   mcand;
        logic [W-1:0]   mplier;
        logic [2*W-1:0] product;
    } t_product_entry;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_BURSTY
    } t_rx_mode;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_stall;
    logic [W-1:0]   i_multiplicand;
    logic [W-1:0]   i_multiplier;
    logic           o_valid;
    logic           i_stall;
    logic [2*W-1:0] o_product;

    t_product_entry pending_products[$];
    int             error_count     = 0;
    int             requests_sent   = 0;
    int             products_seen   = 0;
    int             idle_cycles     = 0;
    int             burst_left      = 0;
    bit             gapless_sender  = 1'b0;

    t_rx_mode       rx_mode   = RX_FREE;
    int             rx_left   = 0;
    int             rx_phase  = 0;
    int             rx_on     = 1;
    int             rx_period = 2;

    booth_radix2_multiplier #(
        .WIDTH(W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_multiplicand (i_multiplicand),
        .i_multiplier   (i_multiplier),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_product      (o_product)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Booth recoding over a W+1 bit upper half so the most negative
    // multiplicand can be subtracted without overflow
    function automatic logic [2*W-1:0] booth_product(input logic [W-1:0] mcand,
                                                     input logic [W-1:0] mplier);
        logic signed [W:0] upper;
        logic signed [W:0] m_ext;
        logic [W-1:0]      lower;
        logic              q_prev;
        t_booth_op         op;
        upper  = '0;
        m_ext  = {mcand[W-1], mcand};
        lower  = mplier;
        q_prev = 1'b0;
        for (int i = 0; i < W; i++) begin
            case ({lower[0], q_prev})
                2'b10:   op = BOOTH_SUB;
                2'b01:   op = BOOTH_ADD;
                default: op = BOOTH_NONE;
            endcase
            case (op)
                BOOTH_SUB: upper = upper - m_ext;
                BOOTH_ADD: upper = upper + m_ext;
                default:   upper = upper;
            endcase
            q_prev = lower[0];
            lower  = {upper[0], lower[W-1:1]};
            upper  = {upper[W], upper[W:1]};
        end
        return {upper[W-1:0], lower};
    endfunction

    task automatic report_error(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // holds the request until accepted, then maybe opens a gap
    task automatic send_request(input logic [W-1:0] mcand, input logic [W-1:0] mplier);
        t_product_entry entry;
        int             gap;
        i_valid        <= 1'b1;
        i_multiplicand <= mcand;
        i_multiplier   <= mplier;
        do
            @(posedge i_clk);
        while (o_stall !== 1'b0);
        entry.mcand   = mcand;
        entry.mplier  = mplier;
        entry.product = booth_product(mcand, mplier);
        pending_products.push_back(entry);
        requests_sent++;
        if (!gapless_sender) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 15);
                gap        = $urandom_range(1, 8);
                i_valid   <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic end_burst();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [W-1:0] edge_operand();
        logic [W-1:0] bit_pos;
        bit_pos = '0;
        bit_pos[WB'($urandom_range(0, W-1))] = 1'b1;
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(W-1){1'b0}}};
            1:       return {1'b0, {(W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            4:       return W'(1);
            5:       return bit_pos;
            6:       return ~bit_pos;
            7:       return {(W/2){2'b01}};
            8:       return {(W/2){2'b10}};
            default: return W'($urandom);
        endcase
    endfunction

    task automatic test_corners();
        logic [W-1:0] min_v;
        logic [W-1:0] max_v;
        min_v = {1'b1, {(W-1){1'b0}}};
        max_v = {1'b0, {(W-1){1'b1}}};
        send_request('0, '0);
        send_request(min_v, min_v);
        send_request(min_v, max_v);
        send_request(max_v, min_v);
        send_request(max_v, max_v);
        send_request('1, '1);
        send_request(W'(1), '1);
        send_request(min_v, W'(1));
        send_request(min_v, '0);
        send_request(min_v, '1);
        // alternating multiplier bits give an add or subtract on every step
        send_request(max_v, {(W/2){2'b01}});
        send_request(min_v, {(W/2){2'b10}});
        send_request({(W/2){2'b10}}, {(W/2){2'b01}});
        send_request(W'(123), W'(-456));
        send_request(W'(-7), '1);
        send_request('1, min_v);
        end_burst();
    endtask

    task automatic test_uniform_random(input int count);
        for (int n = 0; n < count; n++)
            send_request(W'($urandom), W'($urandom));
        end_burst();
    endtask

    task automatic test_edge_random(input int count);
        for (int n = 0; n < count; n++)
            send_request(edge_operand(), edge_operand());
        end_burst();
    endtask

    task automatic test_back_to_back(input int count);
        gapless_sender = 1'b1;
        for (int n = 0; n < count; n++)
            send_request(W'($urandom), W'($urandom));
        end_burst();
        gapless_sender = 1'b0;
    endtask

    // downstream stall follows a mode that changes every so often
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 3));
            rx_left   = $urandom_range(20, 200);
            rx_on     = $urandom_range(1, 8);
            rx_period = rx_on + $urandom_range(1, 8);
            rx_phase  = 0;
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_FREE:  i_stall <= 1'b0;
            RX_LIGHT: i_stall <= ($urandom_range(0, 4) == 0);
            RX_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default: begin
                i_stall  <= (rx_phase < rx_on);
                rx_phase = (rx_phase + 1) % rx_period;
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            products_seen++;
            if (pending_products.size() == 0) begin
                report_error($sformatf("unexpected product %h", o_product));
            end else begin
                if (o_product !== pending_products[0].product)
                    report_error($sformatf("%h * %h: product %h, expected %h",
                                           pending_products[0].mcand,
                                           pending_products[0].mplier,
                                           o_product, pending_products[0].product));
                void'(pending_products.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid === 1'b1 && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing accepted for %0d cycles, %0d products outstanding",
                     idle_cycles, pending_products.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_stall        <= 1'b0;
        i_multiplicand <= '0;
        i_multiplier   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corners();
        test_uniform_random(400);
        test_edge_random(350);
        test_back_to_back(300);

        while (pending_products.size() != 0)
            @(posedge i_clk);
        repeat (2 * W) @(posedge i_clk);

        $display("sent %0d requests, checked %0d products", requests_sent, products_seen);
        $display("covered: operand corners, uniform and edge-biased random, gapless bursts");
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/bm_pkg.sv
src/bm_stage.sv
src/booth_radix2_multiplier.sv
test/booth_radix2_multiplier_tb.sv
